### rtl/tpv_pkg.sv
// ---------------------------------------------------------------------------
// Timed three-position valve package
// Shared types, event codes and constants for the valve driver.
// ---------------------------------------------------------------------------
`default_nettype none

package tpv_pkg;

   // Event codes carried by a request.
   typedef enum logic [2:0] {
      MODE_TICK     = 3'd0,
      MODE_LEVEL    = 3'd1,
      MODE_BINARY   = 3'd2,
      MODE_POSITION = 3'd3,
      MODE_ESTOP    = 3'd4,
      MODE_CLEAR    = 3'd5
   } mode_type;

   // Valve positions.
   localparam logic [1:0] POS_CLOSED = 2'd0;
   localparam logic [1:0] POS_MID    = 2'd1;
   localparam logic [1:0] POS_OPEN   = 2'd2;

   // Level quantisation thresholds at 0.66 and 0.33 of full scale.
   localparam logic [15:0] LEVEL_HIGH_THRESHOLD = 16'd43254;
   localparam logic [15:0] LEVEL_MID_THRESHOLD  = 16'd21627;

   localparam int          TRANSITION_WIDTH = 20;
   localparam int          TIME_WIDTH       = 21;
   localparam logic [TRANSITION_WIDTH-1:0] TRANSITION_RESET = 20'd5000;
   localparam logic [TIME_WIDTH-1:0]       ELAPSED_MAX      = 21'h1FFFFF;

   // One request as held in the input register.
   typedef struct packed {
      mode_type    mode;
      logic [15:0] level;
      logic        open_request;
      logic [1:0]  target_position;
   } req_item_type;

   // One response as held in the result register.
   typedef struct packed {
      logic       accepted;
      logic [1:0] position;
      logic       motor_enable;
      logic       motor_direction;
      logic       moving;
      logic       estop_latched;
      logic [7:0] drive_level;
   } rsp_item_type;

   // Drive value reported for a position: position times 127.
   function automatic logic [7:0] drive_of(input logic [1:0] pos);
      logic [7:0] value;
      case (pos)
         POS_MID:  value = 8'd127;
         POS_OPEN: value = 8'd254;
         default:  value = 8'd0;
      endcase
      return value;
   endfunction

endpackage

`default_nettype wire

### rtl/timed_three_position_valve_unit.sv
// A request accepted into the input register passes through the valve state update into the
// result register, from which the receiver takes it.
// Throughput: one request per cycle while the receiver takes results; the state update is a
// single pass of logic between the input register and the result register.
// Reset clears both pipeline stages, the valve state and sets the transition time to 5000 ms.
// ---------------------------------------------------------------------------
// Timed three-position valve unit
// Top level: input register, valve state update and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module timed_three_position_valve_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [2:0]  req_mode,
   input  wire logic [15:0] req_level,
   input  wire logic        req_open_request,
   input  wire logic [1:0]  req_target_position,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic        rsp_accepted,
   output      logic [1:0]  rsp_position,
   output      logic        rsp_motor_enable,
   output      logic        rsp_motor_direction,
   output      logic        rsp_moving,
   output      logic        rsp_estop_latched,
   output      logic [7:0]  rsp_drive_level,
   input  wire logic        csr_write_enable,
   input  wire logic [19:0] csr_write_data
);

   tpv_pkg::req_item_type req_ff;
   logic                  req_valid_ff, req_valid_in;
   tpv_pkg::rsp_item_type rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  advance;

   // The held request moves on when the result register is free or being emptied.
   assign advance      = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready    = !req_valid_ff || advance;
   assign req_valid_in = (req_valid && req_ready) ? 1'b1 : (advance ? 1'b0 : req_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // Valve state and event update.
   tpv_state u_state (
      .clock            (clock),
      .reset            (reset),
      .step_valid       (advance),
      .item             (req_ff),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .result           (rsp_in)
   );

   // Pipeline valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff.mode            <= tpv_pkg::mode_type'(req_mode);
         req_ff.level           <= req_level;
         req_ff.open_request    <= req_open_request;
         req_ff.target_position <= req_target_position;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // Result ports.
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_accepted         = rsp_ff.accepted;
   assign rsp_position         = rsp_ff.position;
   assign rsp_motor_enable     = rsp_ff.motor_enable;
   assign rsp_motor_direction  = rsp_ff.motor_direction;
   assign rsp_moving           = rsp_ff.moving;
   assign rsp_estop_latched    = rsp_ff.estop_latched;
   assign rsp_drive_level      = rsp_ff.drive_level;

endmodule

`default_nettype wire

### rtl/tpv_state.sv
// ---------------------------------------------------------------------------
// Valve state and event update
// Holds the valve state and the transition time register, and works out
// the state after one request together with the response it reports.
// ---------------------------------------------------------------------------
`default_nettype none

module tpv_state (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step_valid,
   input  wire tpv_pkg::req_item_type  item,
   input  wire logic                   csr_write_enable,
   input  wire logic [19:0]            csr_write_data,
   output tpv_pkg::rsp_item_type       result
);

   logic [19:0] transition_ff;
   logic [1:0]  current_pos_ff, current_pos_in;
   logic [1:0]  goal_pos_ff, goal_pos_in;
   logic        in_motion_ff, in_motion_in;
   logic        latch_ff, latch_in;
   logic        direction_ff, direction_in;
   logic [20:0] elapsed_ff, elapsed_in;
   logic [20:0] move_time_ff, move_time_in;

   logic        accepted;
   logic        go_en;
   logic [1:0]  target;
   logic [1:0]  step_count;
   logic [18:0] half;
   logic [20:0] elapsed_inc;

   assign half = transition_ff[19:1];

   // Next state for the request in the input register.
   always_comb begin
      current_pos_in = current_pos_ff;
      goal_pos_in    = goal_pos_ff;
      in_motion_in   = in_motion_ff;
      latch_in       = latch_ff;
      direction_in   = direction_ff;
      elapsed_in     = elapsed_ff;
      move_time_in   = move_time_ff;
      accepted       = 1'b1;
      go_en          = 1'b0;
      target         = tpv_pkg::POS_CLOSED;
      step_count     = 2'd0;
      elapsed_inc    = elapsed_ff;

      case (item.mode)
         tpv_pkg::MODE_TICK: begin
            if (in_motion_ff) begin
               if (elapsed_ff < tpv_pkg::ELAPSED_MAX) begin
                  elapsed_inc = elapsed_ff + 21'd1;
               end
               if (elapsed_inc >= move_time_ff) begin
                  in_motion_in   = 1'b0;
                  move_time_in   = '0;
                  elapsed_in     = '0;
                  current_pos_in = goal_pos_ff;
               end else begin
                  elapsed_in = elapsed_inc;
               end
            end
         end
         tpv_pkg::MODE_LEVEL: begin
            if (latch_ff) begin
               accepted = 1'b0;
            end else begin
               go_en = 1'b1;
               if (item.level >= tpv_pkg::LEVEL_HIGH_THRESHOLD) begin
                  target = tpv_pkg::POS_OPEN;
               end else if (item.level >= tpv_pkg::LEVEL_MID_THRESHOLD) begin
                  target = tpv_pkg::POS_MID;
               end else begin
                  target = tpv_pkg::POS_CLOSED;
               end
            end
         end
         tpv_pkg::MODE_BINARY: begin
            go_en  = 1'b1;
            target = item.open_request ? tpv_pkg::POS_OPEN : tpv_pkg::POS_CLOSED;
         end
         tpv_pkg::MODE_POSITION: begin
            go_en  = 1'b1;
            target = (item.target_position > tpv_pkg::POS_OPEN) ?
                     tpv_pkg::POS_OPEN : item.target_position;
         end
         tpv_pkg::MODE_ESTOP: begin
            latch_in       = 1'b1;
            in_motion_in   = 1'b0;
            move_time_in   = '0;
            elapsed_in     = '0;
            current_pos_in = tpv_pkg::POS_CLOSED;
            goal_pos_in    = tpv_pkg::POS_CLOSED;
            direction_in   = 1'b0;
         end
         tpv_pkg::MODE_CLEAR: begin
            latch_in = 1'b0;
         end
         default: begin
            accepted = 1'b0;
         end
      endcase

      // Move towards a target position.
      if (go_en) begin
         if (target == current_pos_ff) begin
            // Commanding the present position stops a running move at once.
            if (in_motion_ff) begin
               goal_pos_in    = target;
               in_motion_in   = 1'b0;
               move_time_in   = '0;
               elapsed_in     = '0;
               current_pos_in = target;
            end
         end else begin
            step_count = (target > current_pos_ff) ? (target - current_pos_ff) :
                                                     (current_pos_ff - target);
            move_time_in = (step_count == 2'd2) ? {1'b0, half, 1'b0} : {2'b00, half};
            direction_in = (target > current_pos_ff);
            in_motion_in = 1'b1;
            latch_in     = 1'b0;
            elapsed_in   = '0;
            goal_pos_in  = target;
         end
      end
   end

   // Response reflects the state after the request.
   always_comb begin
      result.accepted         = accepted;
      result.position         = current_pos_in;
      result.motor_enable     = in_motion_in;
      result.motor_direction  = direction_in;
      result.moving           = in_motion_in;
      result.estop_latched    = latch_in;
      result.drive_level      = tpv_pkg::drive_of(current_pos_in);
   end

   // State registers, updated once per request passed on.
   always_ff @(posedge clock) begin
      if (reset) begin
         current_pos_ff <= tpv_pkg::POS_CLOSED;
         goal_pos_ff    <= tpv_pkg::POS_CLOSED;
         in_motion_ff   <= 1'b0;
         latch_ff       <= 1'b0;
         direction_ff   <= 1'b0;
         elapsed_ff     <= '0;
         move_time_ff   <= '0;
      end else if (step_valid) begin
         current_pos_ff <= current_pos_in;
         goal_pos_ff    <= goal_pos_in;
         in_motion_ff   <= in_motion_in;
         latch_ff       <= latch_in;
         direction_ff   <= direction_in;
         elapsed_ff     <= elapsed_in;
         move_time_ff   <= move_time_in;
      end
   end

   // Transition time register; a write of zero is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         transition_ff <= tpv_pkg::TRANSITION_RESET;
      end else if (csr_write_enable && (csr_write_data != '0)) begin
         transition_ff <= csr_write_data;
      end
   end

endmodule

`default_nettype wire

### rtl/tpv_checker.sv
// ---------------------------------------------------------------------------
// Timed three-position valve checker
// Port-level assertions on the valve unit, attached by a bind statement.
// ---------------------------------------------------------------------------
`default_nettype none

module tpv_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_accepted,
   input wire logic [1:0] rsp_position,
   input wire logic       rsp_motor_enable,
   input wire logic       rsp_motor_direction,
   input wire logic       rsp_moving,
   input wire logic       rsp_estop_latched,
   input wire logic [7:0] rsp_drive_level
);

   // A stalled response stays valid and keeps its accepted flag, position, direction, moving flag and drive value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_accepted)
         && $stable(rsp_position) && $stable(rsp_motor_direction)
         && $stable(rsp_moving) && $stable(rsp_drive_level))
      else $error("response changed while stalled");

   // The motor is enabled exactly while a move runs.
   a_enable_moving: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_motor_enable == rsp_moving)
      else $error("motor enable differs from moving");

   // The drive value follows the reported position.
   a_drive_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_position == 2'd0 && rsp_drive_level == 8'd0)
         || (rsp_position == 2'd1 && rsp_drive_level == 8'd127)
         || (rsp_position == 2'd2 && rsp_drive_level == 8'd254))
      else $error("drive level does not match position");

   // Starting a move clears the latch and an emergency stop halts the motor.
   a_latch_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_estop_latched |-> !rsp_moving)
      else $error("moving while emergency latch is set");

endmodule

bind timed_three_position_valve_unit tpv_checker u_tpv_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_accepted         (rsp_accepted),
   .rsp_position         (rsp_position),
   .rsp_motor_enable     (rsp_motor_enable),
   .rsp_motor_direction  (rsp_motor_direction),
   .rsp_moving           (rsp_moving),
   .rsp_estop_latched    (rsp_estop_latched),
   .rsp_drive_level      (rsp_drive_level)
);

`default_nettype wire
